// ----- hdl/ladpcm_pkg.sv -----
`timescale 1ns / 1ps

package ladpcm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 15;
  localparam int SCALE_W  = 10;

  localparam logic [STEP_W-1:0] STEP_INIT = 15'd127;
  localparam logic [STEP_W-1:0] STEP_MIN  = 15'd127;
  localparam logic [STEP_W-1:0] STEP_MAX  = 15'd24576;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // one decode operation handed from the front to the core
  typedef struct packed {
    logic [3:0] code;
    logic       last;
    logic       restart;
    logic       emit;
  } nib_op_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } res_t;

  function automatic logic [SCALE_W-1:0] step_scale(input logic [2:0] mag);
    logic [SCALE_W-1:0] s;
    unique case (mag) inside
      3'd0, 3'd1, 3'd2, 3'd3: s = 10'd230;
      3'd4:                   s = 10'd307;
      3'd5:                   s = 10'd409;
      3'd6:                   s = 10'd512;
      default:                s = 10'd614;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/ladpcm_fifo.sv -----
`timescale 1ns / 1ps

module ladpcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt == FULL_CNT);
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= FULL_CNT)
    else $error("fifo count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !rd_en) |=> full)
    else $error("fifo lost an entry while full");
  a_empty_stay: assert property (@(posedge clk) disable iff (rst)
    (empty && !wr_en) |=> empty)
    else $error("fifo gained an entry without a write");
`endif

endmodule

// ----- hdl/ladpcm_front.sv -----
`timescale 1ns / 1ps

module ladpcm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           code_byte,
  input  logic [1:0]           nibble_count,
  input  logic                 restart,
  output logic                 op_push,
  output ladpcm_pkg::nib_op_t  op,
  input  logic                 op_full
);

  logic       pending;
  logic       pending_next;
  logic [3:0] hi_code;
  logic       accept;

  assign full   = pending || op_full;
  assign accept = push && !full;

  always_comb begin
    op           = '0;
    op_push      = 1'b0;
    pending_next = pending;
    if (pending) begin
      op.code    = hi_code;
      op.last    = 1'b1;
      op.restart = 1'b0;
      op.emit    = 1'b1;
      op_push    = !op_full;
      if (!op_full) begin
        pending_next = 1'b0;
      end
    end else if (accept) begin
      op.code      = code_byte[3:0];
      op.last      = (nibble_count == 2'd1);
      op.restart   = restart;
      op.emit      = (nibble_count != 2'd0);
      op_push      = (nibble_count != 2'd0) || restart;
      pending_next = nibble_count[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_code <= code_byte[7:4];
    end
  end

endmodule

// ----- hdl/ladpcm_core.sv -----
`timescale 1ns / 1ps

module ladpcm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  input  ladpcm_pkg::nib_op_t op,
  output logic                op_pop,
  input  logic                res_full,
  output logic                res_push,
  output ladpcm_pkg::res_t    res
);

  logic [ladpcm_pkg::STEP_W-1:0]          step;
  logic signed [ladpcm_pkg::SAMPLE_W-1:0] hist;

  logic [ladpcm_pkg::STEP_W-1:0]          step_in;
  logic signed [ladpcm_pkg::SAMPLE_W-1:0] hist_in;
  logic signed [23:0]                     leak_p;
  logic signed [23:0]                     leak_adj;
  logic signed [ladpcm_pkg::SAMPLE_W-1:0] leaked;
  logic [3:0]                             odd;
  logic [18:0]                            diff_full;
  logic [14:0]                            diff_sat;
  logic signed [17:0]                     sum;
  logic signed [ladpcm_pkg::SAMPLE_W-1:0] hist_next;
  logic [24:0]                            step_prod;
  logic [16:0]                            step_raw;
  logic [ladpcm_pkg::STEP_W-1:0]          step_next;

  assign op_pop   = op_valid && !res_full;
  assign res_push = op_pop && op.emit;

  always_comb begin
    step_in  = op.restart ? ladpcm_pkg::STEP_INIT : step;
    hist_in  = op.restart ? '0 : hist;
    // leak: h*254/256, toward zero
    leak_p   = (24'(hist_in) <<< 8) - (24'(hist_in) <<< 1);
    leak_adj = leak_p + (leak_p[23] ? 24'sd255 : 24'sd0);
    leaked   = leak_adj[23:8];

    odd       = {op.code[2:0], 1'b1};
    diff_full = 19'(odd) * 19'(step_in);
    diff_sat  = (diff_full[18]) ? 15'h7fff : diff_full[17:3];

    if (op.code[3]) begin
      sum = 18'(leaked) - $signed({3'b000, diff_sat});
    end else begin
      sum = 18'(leaked) + $signed({3'b000, diff_sat});
    end
    if (sum > 18'(ladpcm_pkg::SAMPLE_MAX)) begin
      hist_next = ladpcm_pkg::SAMPLE_MAX;
    end else if (sum < 18'(ladpcm_pkg::SAMPLE_MIN)) begin
      hist_next = ladpcm_pkg::SAMPLE_MIN;
    end else begin
      hist_next = sum[15:0];
    end

    step_prod = 25'(ladpcm_pkg::step_scale(op.code[2:0])) * 25'(step_in);
    step_raw  = step_prod[24:8];
    if (step_raw < 17'(ladpcm_pkg::STEP_MIN)) begin
      step_next = ladpcm_pkg::STEP_MIN;
    end else if (step_raw > 17'(ladpcm_pkg::STEP_MAX)) begin
      step_next = ladpcm_pkg::STEP_MAX;
    end else begin
      step_next = step_raw[14:0];
    end

    res.sample = hist_next;
    res.last   = op.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ladpcm_pkg::STEP_INIT;
      hist <= '0;
    end else if (op_pop) begin
      if (op.emit) begin
        step <= step_next;
        hist <= hist_next;
      end else begin
        step <= step_in;
        hist <= hist_in;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (step >= ladpcm_pkg::STEP_MIN) && (step <= ladpcm_pkg::STEP_MAX))
    else $error("step out of range");
  a_push_needs_pop: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (op_pop && !res_full))
    else $error("result beat without an operation");
  a_bare_restart: assert property (@(posedge clk) disable iff (rst)
    (op_pop && op.restart && !op.emit) |=>
      (step == ladpcm_pkg::STEP_INIT) && (hist == '0))
    else $error("restart did not clear state");
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !op_pop |=> ($stable(step) && $stable(hist)))
    else $error("state moved without an operation");
`endif

endmodule

// ----- hdl/leaky_adpcm_nibble_decoder.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake          | beat
// ---------+-----------+--------------------+----------------------------------
// input    | in        | push / full        | code_byte, nibble_count, restart
// result   | out       | pop / empty        | sample, last
//
// the decode core decodes each code combinationally; a two-code byte holds full
// while the front issues the high nibble
// first result reaches the ports through the op queue and the result queue
// rst is synchronous: step 127, history 0, both queues emptied
// a stalled result side fills the result queue, then the op queue, then full

module leaky_adpcm_nibble_decoder #(
  parameter int OP_DEPTH  = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         code_byte,
  input  logic [1:0]         nibble_count,
  input  logic               restart,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample,
  output logic               last
);

  ladpcm_pkg::nib_op_t fe_op;
  ladpcm_pkg::nib_op_t q_op;
  ladpcm_pkg::res_t    core_res;
  ladpcm_pkg::res_t    out_res;
  logic                fe_push;
  logic                op_full;
  logic                op_empty;
  logic                op_pop;
  logic                res_full;
  logic                res_push;

  ladpcm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .code_byte    (code_byte),
    .nibble_count (nibble_count),
    .restart      (restart),
    .op_push      (fe_push),
    .op           (fe_op),
    .op_full      (op_full)
  );

  ladpcm_fifo #(
    .WIDTH ($bits(ladpcm_pkg::nib_op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_push),
    .wr_data (fe_op),
    .full    (op_full),
    .rd_en   (op_pop),
    .rd_data (q_op),
    .empty   (op_empty)
  );

  ladpcm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!op_empty),
    .op       (q_op),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (core_res)
  );

  ladpcm_fifo #(
    .WIDTH ($bits(ladpcm_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (core_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign sample = out_res.sample;
  assign last   = out_res.last;

endmodule

// ----- tb/ladpcm_sample_check.sv -----
`timescale 1ns / 1ps

module ladpcm_sample_check (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  logic                                   full,
  input  logic [7:0]                             code_byte,
  input  logic [1:0]                             nibble_count,
  input  logic                                   restart,
  input  logic                                   empty,
  input  logic                                   pop,
  input  logic signed [ladpcm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                   last,
  output int                                     mismatch_count,
  output int                                     samples_owed
);

  localparam int SCALE_TAB [8] = '{230, 230, 230, 230, 307, 409, 512, 614};
  localparam int DIFF_MAX      = 32767;

  ladpcm_pkg::res_t sample_q[$];
  int               step_sz;
  int               hist;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one code through leak, add/subtract with saturation, then step update
  function automatic logic signed [ladpcm_pkg::SAMPLE_W-1:0] decode_code(
    input logic [3:0] code
  );
    int mag;
    int h;
    int diff;
    int nstep;
    mag  = int'(code[2:0]);
    h    = (hist * 254) / 256;
    diff = ((1 + 2 * mag) * step_sz) >>> 3;
    if (diff > DIFF_MAX)
      diff = DIFF_MAX;
    if (code[3])
      h = h - diff;
    else
      h = h + diff;
    if (h > int'(ladpcm_pkg::SAMPLE_MAX))
      h = int'(ladpcm_pkg::SAMPLE_MAX);
    if (h < int'(ladpcm_pkg::SAMPLE_MIN))
      h = int'(ladpcm_pkg::SAMPLE_MIN);
    nstep = (SCALE_TAB[mag] * step_sz) >>> 8;
    if (nstep < int'(ladpcm_pkg::STEP_MIN))
      nstep = int'(ladpcm_pkg::STEP_MIN);
    if (nstep > int'(ladpcm_pkg::STEP_MAX))
      nstep = int'(ladpcm_pkg::STEP_MAX);
    step_sz = nstep;
    hist    = h;
    return h[ladpcm_pkg::SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    ladpcm_pkg::res_t want;
    int               cnt;
    if (rst) begin
      sample_q.delete();
      mismatch_count = 0;
      step_sz        = int'(ladpcm_pkg::STEP_INIT);
      hist           = 0;
    end else begin
      if (pop && !empty) begin
        if (sample_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d last %0b", sample, last));
        end else begin
          want = sample_q.pop_front();
          if (sample !== want.sample)
            report_mismatch($sformatf("sample %0d, want %0d", sample, want.sample));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
      if (push && !full) begin
        if (restart) begin
          step_sz = int'(ladpcm_pkg::STEP_INIT);
          hist    = 0;
        end
        cnt = (nibble_count > 2'd2) ? 2 : int'(nibble_count);
        for (int k = 0; k < cnt; k++) begin
          want.sample = decode_code((k == 0) ? code_byte[3:0] : code_byte[7:4]);
          want.last   = (k + 1 == cnt);
          sample_q.push_back(want);
        end
      end
    end
    samples_owed <= sample_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_BYTES = 950;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  logic                                   clk          = 1'b0;
  logic                                   rst          = 1'b1;
  logic                                   push         = 1'b0;
  logic [7:0]                             code_byte    = 8'h00;
  logic [1:0]                             nibble_count = 2'd0;
  logic                                   restart      = 1'b0;
  logic                                   pop          = 1'b0;
  logic                                   steady       = 1'b0;
  logic                                   full;
  logic                                   empty;
  logic signed [ladpcm_pkg::SAMPLE_W-1:0] sample;
  logic                                   last;
  int                                     mismatch_count;
  int                                     samples_owed;
  int                                     quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  leaky_adpcm_nibble_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .code_byte    (code_byte),
    .nibble_count (nibble_count),
    .restart      (restart),
    .empty        (empty),
    .pop          (pop),
    .sample       (sample),
    .last         (last)
  );

  ladpcm_sample_check u_sample_check (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .code_byte      (code_byte),
    .nibble_count   (nibble_count),
    .restart        (restart),
    .empty          (empty),
    .pop            (pop),
    .sample         (sample),
    .last           (last),
    .mismatch_count (mismatch_count),
    .samples_owed   (samples_owed)
  );

  always @(negedge clk) begin
    pop <= steady || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [1:0] cnt, input logic rs);
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push         <= 1'b1;
    code_byte    <= b;
    nibble_count <= cnt;
    restart      <= rs;
    do
      @(posedge clk);
    while (full);
  endtask

  function automatic logic [3:0] loud_nibble();
    return {$urandom_range(1) == 1, 2'b11, $urandom_range(1) == 1};
  endfunction

  initial begin
    logic [7:0] b;
    logic [1:0] cnt;
    int         pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // step growth to the clamp and positive saturation, then the negative side
    send_byte(8'h00, 2'd2, 1'b1);
    repeat (6) send_byte(8'h77, 2'd2, 1'b0);
    repeat (6) send_byte(8'hff, 2'd2, 1'b0);
    // count of three, single nibble, zero count with and without restart
    send_byte(8'h88, 2'd3, 1'b0);
    send_byte(8'h0f, 2'd1, 1'b0);
    send_byte(8'ha5, 2'd0, 1'b1);
    send_byte(8'h31, 2'd0, 1'b0);
    send_byte(8'h64, 2'd2, 1'b0);
    send_byte(8'hec, 2'd3, 1'b1);
    send_byte(8'hb9, 2'd1, 1'b0);
    send_byte(8'hd2, 2'd2, 1'b0);

    for (int i = 0; i < RANDOM_BYTES; i++) begin
      steady = (i >= 400 && i < 560);
      pick   = $urandom_range(99);
      if (pick < 5)
        cnt = 2'd0;
      else if (pick < 20)
        cnt = 2'd1;
      else if (pick < 30)
        cnt = 2'd3;
      else
        cnt = 2'd2;
      if ($urandom_range(99) < 25)
        b = {loud_nibble(), loud_nibble()};
      else
        b = 8'($urandom_range(255));
      send_byte(b, cnt, $urandom_range(99) < 5);
    end
    steady = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    while (samples_owed != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
